// ===== design/wbds_pkg.sv =====
// Shared types, constants and calendar helpers for the weekday stepping core.
// No dependencies; imported by wbds_ctrl, wbds_dp and weekday_by_date_stepping_core.
package wbds_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int WDAY_W  = 3;
   localparam int MOD25_W = 5;
   localparam int QUOT_W  = 10;   // year / 25 for a 14-bit year

   // Reset date: 16 July 2018, a Monday
   localparam logic [YEAR_W-1:0]  RESET_YEAR    = 14'd2018;
   localparam logic [MONTH_W-1:0] RESET_MONTH   = 4'd7;
   localparam logic [DAY_W-1:0]   RESET_DAY     = 5'd16;
   localparam logic [WDAY_W-1:0]  RESET_WEEKDAY = 3'd1;
   localparam logic [MOD25_W-1:0] RESET_MOD25   = 5'd18;   // 2018 mod 25

   localparam logic [WDAY_W-1:0]  WDAY_MON = 3'd1;
   localparam logic [WDAY_W-1:0]  WDAY_SUN = 3'd7;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;

   localparam logic [MOD25_W-1:0] MOD25_MAX = 5'd24;

   // floor(y / 25) = (y * RECIP25) >> RECIP_SHIFT, exact for y < 16384
   localparam int                 RECIP_SHIFT = 20;
   localparam logic [15:0]        RECIP25     = 16'd41944;

   typedef struct packed {
      logic load_tgt;   // capture the request beat
      logic step;       // move current date one day toward the target
      logic load_rsp;   // capture the current weekday into the output register
   } wbds_cmd_type;

   typedef struct packed {
      logic tgt_ok;     // target is a real date
      logic at_target;  // current date equals target
   } wbds_sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== design/wbds_ctrl.sv =====
// Sequencer for the weekday stepping core: handshakes and datapath commands.
// Depends on wbds_pkg.
module wbds_ctrl
   import wbds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  wbds_sts_type sts,
   output wbds_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load_tgt = (state_ff == ST_IDLE) && req_valid;
      cmd.step     = (state_ff == ST_STEP) && !sts.at_target;
      cmd.load_rsp = (state_ff == ST_DONE) && rsp_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.tgt_ok ? ST_STEP : ST_DONE;
         end
         ST_STEP: begin
            if (sts.at_target) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_step_at_target: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.at_target)
      else $error("step issued with current date already at target");

   a_rsp_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while holding a beat");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.load_rsp) |-> !(req_valid && req_ready))
      else $error("request accepted while an item is in flight");
`endif

endmodule

// ===== design/wbds_dp.sv =====
// Datapath of the weekday stepping core: target capture, validity, day stepper.
// Depends on wbds_pkg.
module wbds_dp
   import wbds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  wbds_cmd_type       cmd,
   output wbds_sts_type       sts,
   input  logic [DAY_W-1:0]   req_target_day,
   input  logic [MONTH_W-1:0] req_target_month,
   input  logic [YEAR_W-1:0]  req_target_year,
   output logic [WDAY_W-1:0]  rsp_weekday
);

   // target capture
   logic [DAY_W-1:0]   tgt_day_ff;
   logic [MONTH_W-1:0] tgt_month_ff;
   logic [YEAR_W-1:0]  tgt_year_ff;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [29:0]        prod;

   // current date
   logic [DAY_W-1:0]   cur_day_ff, cur_day_in;
   logic [MONTH_W-1:0] cur_month_ff, cur_month_in;
   logic [YEAR_W-1:0]  cur_year_ff, cur_year_in;
   logic [MOD25_W-1:0] cur_mod25_ff, cur_mod25_in;
   logic [WDAY_W-1:0]  cur_wday_ff, cur_wday_in;
   logic [WDAY_W-1:0]  rsp_weekday_ff;

   logic [YEAR_W-1:0]  quot_x25, tgt_rem25;
   logic               tgt_leap, cur_leap, fwd;
   logic [DAY_W-1:0]   tgt_len, cur_len, prev_len;
   logic [MONTH_W-1:0] prev_month;
   logic [22:0]        cur_key, tgt_key;

   // year / 25 by reciprocal, registered before the back-multiply
   assign prod    = 30'(tgt_year_ff) * 30'(RECIP25);
   assign quot_in = prod[RECIP_SHIFT +: QUOT_W];

   assign quot_x25  = (YEAR_W'(quot_ff) << 4) + (YEAR_W'(quot_ff) << 3) + YEAR_W'(quot_ff);
   assign tgt_rem25 = tgt_year_ff - quot_x25;
   assign tgt_leap  = (tgt_year_ff[1:0] == 2'b00) &&
                      ((tgt_rem25 != '0) || (tgt_year_ff[3:0] == 4'b0000));
   assign tgt_len   = month_len(tgt_month_ff, tgt_leap);

   assign cur_leap  = (cur_year_ff[1:0] == 2'b00) &&
                      ((cur_mod25_ff != '0) || (cur_year_ff[3:0] == 4'b0000));
   assign cur_len   = month_len(cur_month_ff, cur_leap);
   // previous month: only February depends on leap, and it is in the same year
   assign prev_month = (cur_month_ff == MONTH_JAN) ? MONTH_DEC : cur_month_ff - 4'd1;
   assign prev_len   = month_len(prev_month, cur_leap);

   assign cur_key = {cur_year_ff, cur_month_ff, cur_day_ff};
   assign tgt_key = {tgt_year_ff, tgt_month_ff, tgt_day_ff};
   assign fwd     = cur_key < tgt_key;

   // month range is implied by a non-zero length
   assign sts.tgt_ok    = (tgt_day_ff != '0) && (tgt_day_ff <= tgt_len);
   assign sts.at_target = (cur_key == tgt_key);

   always_comb begin
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      cur_mod25_in = cur_mod25_ff;
      cur_wday_in  = cur_wday_ff;
      if (cmd.step) begin
         if (fwd) begin
            cur_wday_in = (cur_wday_ff == WDAY_SUN) ? WDAY_MON : cur_wday_ff + 3'd1;
            if (cur_day_ff < cur_len) begin
               cur_day_in = cur_day_ff + 5'd1;
            end else begin
               cur_day_in = FIRST_DAY;
               if (cur_month_ff == MONTH_DEC) begin
                  cur_month_in = MONTH_JAN;
                  cur_year_in  = cur_year_ff + 14'd1;
                  cur_mod25_in = (cur_mod25_ff == MOD25_MAX) ? '0 : cur_mod25_ff + 5'd1;
               end else begin
                  cur_month_in = cur_month_ff + 4'd1;
               end
            end
         end else begin
            cur_wday_in = (cur_wday_ff == WDAY_MON) ? WDAY_SUN : cur_wday_ff - 3'd1;
            if (cur_day_ff > FIRST_DAY) begin
               cur_day_in = cur_day_ff - 5'd1;
            end else begin
               cur_day_in   = prev_len;
               cur_month_in = prev_month;
               if (cur_month_ff == MONTH_JAN) begin
                  cur_year_in  = cur_year_ff - 14'd1;
                  cur_mod25_in = (cur_mod25_ff == '0) ? MOD25_MAX : cur_mod25_ff - 5'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      if (cmd.load_tgt) begin
         tgt_day_ff   <= req_target_day;
         tgt_month_ff <= req_target_month;
         tgt_year_ff  <= req_target_year;
      end
      if (cmd.load_rsp) begin
         rsp_weekday_ff <= cur_wday_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= RESET_DAY;
         cur_month_ff <= RESET_MONTH;
         cur_year_ff  <= RESET_YEAR;
         cur_mod25_ff <= RESET_MOD25;
         cur_wday_ff  <= RESET_WEEKDAY;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cur_mod25_ff <= cur_mod25_in;
         cur_wday_ff  <= cur_wday_in;
      end
   end

   assign rsp_weekday = rsp_weekday_ff;

`ifndef SYNTHESIS
   a_mod25_tracks_year: assert property (@(posedge clock) disable iff (reset)
      32'(cur_mod25_ff) == (32'(cur_year_ff) % 25))
      else $error("year mod 25 tracker out of step with year");

   a_cur_date_real: assert property (@(posedge clock) disable iff (reset)
      (cur_day_ff != '0) && (cur_day_ff <= cur_len))
      else $error("current date is not a real date");

   a_step_turns_weekday: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (cur_wday_ff != $past(cur_wday_ff)) &&
                   (cur_key != $past(cur_key)))
      else $error("day step left date or weekday unchanged");
`endif

endmodule

// ===== design/weekday_by_date_stepping_core.sv =====
// Top level of the weekday stepping core: sequencer plus datapath.
// Depends on wbds_pkg, wbds_ctrl and wbds_dp.
//
//   channel | direction | ports                                   | beat
//   req     | in        | req_target_day/_month/_year             | one target date
//   rsp     | out       | rsp_weekday                             | 1 Monday .. 7 Sunday
//
// Steps: a beat taken in IDLE forms year/25 in MUL, runs the validity check in
// CHECK, then in STEP moves the held date one calendar day per cycle toward the
// target until it matches, and in DONE loads the output register. The single
// day stepper sets the pace.
// An impossible date skips STEP and reports the held weekday unchanged.
// Reset (synchronous, high) sets the held date to 16 July 2018, a Monday.
// A stalled rsp beat waits in the output register; the next req beat is taken
// meanwhile and only holds in DONE until the register frees.
module weekday_by_date_stepping_core
   import wbds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [DAY_W-1:0]   req_target_day,
   input  logic [MONTH_W-1:0] req_target_month,
   input  logic [YEAR_W-1:0]  req_target_year,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [WDAY_W-1:0]  rsp_weekday
);

   wbds_cmd_type cmd;
   wbds_sts_type sts;

   // handshakes and sequencing
   wbds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // held date, day stepper and output register
   wbds_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_target_day   (req_target_day),
      .req_target_month (req_target_month),
      .req_target_year  (req_target_year),
      .rsp_weekday      (rsp_weekday)
   );

endmodule

// ===== tb/sv/weekday_by_date_stepping_core_tb.sv =====
// Self-checking testbench for weekday_by_date_stepping_core: drives target dates,
// predicts the weekday of each from its own calendar model and checks every rsp beat.
// Depends on wbds_pkg and the RTL under design/.
module weekday_by_date_stepping_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wbds_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [DAY_W-1:0]   req_target_day;
   logic [MONTH_W-1:0] req_target_month;
   logic [YEAR_W-1:0]  req_target_year;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [WDAY_W-1:0]  rsp_weekday;

   // Held date as the block should see it after every accepted req beat
   logic [YEAR_W-1:0]  held_year;
   logic [MONTH_W-1:0] held_month;
   logic [DAY_W-1:0]   held_day;
   logic [WDAY_W-1:0]  held_weekday;

   logic [WDAY_W-1:0]  weekdays_due[$];   // predicted rsp beats, oldest first
   int                 mismatches;
   int                 cycle_count;
   int                 send_idle_pct;     // chance per cycle that the sender holds back
   int                 recv_idle_pct;     // chance per cycle that rsp_ready is low
   int                 hold_off;          // cycles of forced rsp back-pressure still to run

   weekday_by_date_stepping_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_day   (req_target_day),
      .req_target_month (req_target_month),
      .req_target_year  (req_target_year),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_weekday      (rsp_weekday)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Run-away guard; also catches a prediction that never gets its beat
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Calendar model
   // ------------------------------------------------------------------

   // Proleptic Gregorian leap rule; year 0 counts as leap
   function automatic bit is_leap(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // Zero for a month number outside 1..12, which makes any day invalid
   function automatic int days_in_month(input int mo, input int yr);
      case (mo)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap(yr) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Days since a notional 1 Jan of year 0. Leap years before yr are counted
   // with ceilings so that year 0 itself is included.
   function automatic int day_serial(input int yr, input int mo, input int dy);
      int serial;
      int m;
      serial = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + dy;
      for (m = 1; m < mo; m++)
         serial += days_in_month(m, yr);
      return serial;
   endfunction

   // Moves the held date to the target and returns the weekday the block should
   // report. An impossible date leaves everything alone and reports the held weekday.
   function automatic logic [WDAY_W-1:0] step_calendar(input logic [DAY_W-1:0]   dy,
                                                       input logic [MONTH_W-1:0] mo,
                                                       input logic [YEAR_W-1:0]  yr);
      int shift;
      if (dy >= 1 && dy <= days_in_month(int'(mo), int'(yr))) begin
         shift = (day_serial(int'(yr), int'(mo), int'(dy))
                  - day_serial(int'(held_year), int'(held_month), int'(held_day))) % 7;
         if (shift < 0)
            shift += 7;   // % truncates towards zero for a backward step
         held_weekday = WDAY_W'((int'(held_weekday) - 1 + shift) % 7 + 1);
         held_year    = yr;
         held_month   = mo;
         held_day     = dy;
      end
      return held_weekday;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers and checker
   // ------------------------------------------------------------------

   // Entered just after a falling edge and left just after one, so that each
   // step sees at most one write to req_valid.
   task automatic send_date(input logic [DAY_W-1:0]   dy,
                            input logic [MONTH_W-1:0] mo,
                            input logic [YEAR_W-1:0]  yr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_target_day   <= dy;
      req_target_month <= mo;
      req_target_year  <= yr;
      do
         @(posedge clock);
      while (!req_ready);
      weekdays_due.push_back(step_calendar(dy, mo, yr));
      @(negedge clock);
   endtask

   // Sender goes quiet until every predicted beat has been seen; always leaves
   // on a later falling edge than the one it drops req_valid on
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (weekdays_due.size() != 0);
   endtask

   // Receiver: random stalls, or a solid hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off  = hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every rsp beat is matched against the oldest prediction
   always @(posedge clock) begin : check_weekday
      logic [WDAY_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (weekdays_due.size() == 0) begin
            $error("rsp_weekday: expected no beat, got %0d", rsp_weekday);
            mismatches++;
         end else begin
            want = weekdays_due.pop_front();
            if (rsp_weekday !== want) begin
               $error("rsp_weekday: expected %0d, got %0d", want, rsp_weekday);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Same date, single-day steps both ways, year roll-over both ways and the
   // February ends around the 400- and 100-year rules. Leaves the held date
   // in mid 2019 so that later traffic stays cheap to step.
   task automatic test_calendar_edges();
      send_date(16, 7, 2018);    // same as the reset date
      send_date(17, 7, 2018);
      send_date(15, 7, 2018);
      send_date(31, 12, 2018);
      send_date(1, 1, 2019);     // forward over new year
      send_date(31, 12, 2018);   // and back again
      send_date(28, 2, 2000);
      send_date(29, 2, 2000);    // leap by the 400 rule
      send_date(1, 3, 2000);
      send_date(28, 2, 1900);
      send_date(1, 3, 1900);     // no 29th in a plain century year
      send_date(29, 2, 2020);
      send_date(30, 6, 2019);
   endtask

   // Impossible dates: held state must not move. Also swings every bit of
   // every field, including year 0 and the top year, without a long walk.
   task automatic test_invalid_dates();
      send_date(29, 2, 1900);
      send_date(29, 2, 2019);
      send_date(29, 2, 2100);
      send_date(31, 4, 2019);
      send_date(0, 5, 2019);
      send_date(10, 0, 2019);
      send_date(10, 13, 2019);
      send_date(31, 15, 16383);
      send_date(30, 2, 0);
      send_date(29, 2, 16383);
      send_date(0, 0, 0);
   endtask

   // Receiver holds off for a long stretch while short steps keep coming, so
   // the output register fills and req_ready drops; then the sender waits for
   // every beat to drain.
   task automatic test_output_stall();
      int n;
      wait_for_results();
      hold_off = HOLD_OFF_CYCLES;
      for (n = 0; n < 10; n++)
         send_date(DAY_W'($urandom_range(days_in_month(int'(held_month),
                                                       int'(held_year)), 1)),
                   held_month, held_year);
      wait_for_results();
   endtask

   // Mostly valid dates within a year or so of the held one, some February
   // ends, a few longer jumps, and a tail of impossible dates with random years.
   task automatic test_random_walk(input int count);
      int n;
      int pick;
      int yr;
      int mo;
      int dy;
      int short_months[5] = '{2, 4, 6, 9, 11};
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            yr = int'(held_year) + int'($urandom_range(2)) - 1;
            mo = $urandom_range(12, 1);
            dy = $urandom_range(days_in_month(mo, yr), 1);
         end else if (pick < 80) begin
            // 29th lands on leap and plain years alike
            yr = int'(held_year) + int'($urandom_range(8)) - 4;
            mo = 2;
            dy = $urandom_range(29, 27);
         end else if (pick < 85) begin
            yr = 1995 + $urandom_range(50);
            mo = $urandom_range(12, 1);
            dy = $urandom_range(days_in_month(mo, yr), 1);
         end else begin
            yr = $urandom_range(16383);
            case ($urandom_range(3))
               0: begin
                  mo = 0;
                  dy = $urandom_range(31);
               end
               1: begin
                  mo = $urandom_range(15, 13);
                  dy = $urandom_range(31);
               end
               2: begin
                  mo = $urandom_range(12, 1);
                  dy = 0;
               end
               default: begin
                  mo = short_months[$urandom_range(4)];
                  dy = $urandom_range(31, days_in_month(mo, yr) + 1);
               end
            endcase
         end
         send_date(DAY_W'(dy), MONTH_W'(mo), YEAR_W'(yr));
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_target_day   = '0;
      req_target_month = '0;
      req_target_year  = '0;
      rsp_ready        = 1'b0;
      mismatches       = 0;
      cycle_count      = 0;
      hold_off         = 0;
      send_idle_pct    = 15;
      recv_idle_pct    = 63;
      held_year        = RESET_YEAR;
      held_month       = RESET_MONTH;
      held_day         = RESET_DAY;
      held_weekday     = RESET_WEEKDAY;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_calendar_edges();
      test_invalid_dates();
      test_output_stall();
      test_random_walk(35);

      send_idle_pct = 63;
      recv_idle_pct = 15;
      test_random_walk(35);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_walk(36);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
